// ===== rtl/core/intel_hex_record_loader_top_defines.svh =====
// ----------------------------------------------------------------------------
// Intel HEX record loader assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef INTEL_HEX_RECORD_LOADER_TOP_DEFINES_SVH
`define INTEL_HEX_RECORD_LOADER_TOP_DEFINES_SVH

// Same-cycle implication.
`define IHEX_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ihex assertion failed");

// Next-cycle implication.
`define IHEX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ihex assertion failed");

`endif

// ===== rtl/core/ihex_pkg.sv =====
// ----------------------------------------------------------------------------
// Intel HEX loader package
// Codes, phase encodings and the hex digit decoder shared by the loader.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ihex_pkg;

    typedef logic [2:0] status_t;
    typedef logic [2:0] phase_t;

    // Input item kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Result kinds
    localparam logic RESULT_WRITE  = 1'b0;
    localparam logic RESULT_FINISH = 1'b1;

    // Finish status codes
    localparam status_t STATUS_OK       = 3'd0;
    localparam status_t STATUS_PARSE    = 3'd1;
    localparam status_t STATUS_TYPE     = 3'd2;
    localparam status_t STATUS_RANGE    = 3'd3;
    localparam status_t STATUS_CHECKSUM = 3'd4;

    // Parser phases
    localparam phase_t PH_COLON   = 3'd0;
    localparam phase_t PH_COUNT   = 3'd1;
    localparam phase_t PH_ADDR_HI = 3'd2;
    localparam phase_t PH_ADDR_LO = 3'd3;
    localparam phase_t PH_TYPE    = 3'd4;
    localparam phase_t PH_DATA    = 3'd5;
    localparam phase_t PH_CHECK   = 3'd6;
    localparam phase_t PH_SKIP    = 3'd7;

    // Record types
    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;

    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    // Decode one ASCII hex digit: bit 4 flags a valid digit, bits 3:0 hold it.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        return r;
    endfunction

endpackage

// ===== rtl/core/intel_hex_record_loader_top.sv =====
// ----------------------------------------------------------------------------
// Intel HEX record loader
// Streams ASCII Intel HEX text and emits memory writes and a final status.
// ----------------------------------------------------------------------------
// The loader takes one character transaction per clock and produces at most
// one result per character, in the next cycle, from a single output register.
// Data bytes of type-00 records that fall inside the window
// [window_start, window_start + window_size) come out as writes of offset
// and data as soon as each byte is complete; the record checksum is checked
// after its last data byte. A type-01 record finishes with status ok, and any
// error finishes with its code; after that, characters are dropped until an
// end-of-input transaction re-arms the parser. End of input between lines
// finishes with ok, inside a record with a parse error. Throughput is one
// character per cycle: the parser state update is one short combinational
// step, and char_stall rises only while the output register holds a result
// that the consumer is stalling. Configuration writes are taken every cycle
// (cfg_ready is always high) and must be made while the loader is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "intel_hex_record_loader_top_defines.svh"

module intel_hex_record_loader_top (
    input  logic                  clk,
    input  logic                  rst_n,
    // character channel
    input  logic                  char_valid,
    output logic                  char_stall,
    input  logic                  kind,
    input  logic [7:0]            character,
    // result channel
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic                  result_kind,
    output logic [15:0]           write_offset,
    output logic [7:0]            write_data,
    output ihex_pkg::status_t     status,
    // configuration channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [15:0]           cfg_data
);

    import ihex_pkg::*;

    localparam logic CFG_WINDOW_START = 1'b0;
    localparam logic CFG_WINDOW_SIZE  = 1'b1;

    // Configuration
    logic [15:0] window_start_reg;
    logic [15:0] window_size_reg;

    // Parser state
    phase_t      phase_reg,          phase_next;
    logic [3:0]  high_nibble_reg,    high_nibble_next;
    logic        second_digit_reg,   second_digit_next;
    logic [7:0]  bytes_left_reg,     bytes_left_next;
    logic [16:0] record_address_reg, record_address_next;
    logic [7:0]  running_sum_reg,    running_sum_next;
    logic        finished_reg,       finished_next;

    // Output register
    logic        result_valid_reg;
    logic        result_kind_reg,    result_kind_next;
    logic [15:0] write_offset_reg,   write_offset_next;
    logic [7:0]  write_data_reg,     write_data_next;
    status_t     status_reg,         status_next;
    logic        emit;

    logic        char_accept;
    logic [4:0]  digit;
    logic [7:0]  byte_val;
    logic [7:0]  sum_val;
    logic [16:0] window_end;
    logic        in_window;

    assign cfg_ready   = 1'b1;
    // Hold the input only while a finished result waits on a stalled consumer.
    assign char_stall  = result_valid_reg & result_stall;
    assign char_accept = char_valid & ~char_stall;

    assign digit      = hex_digit(character);
    assign byte_val   = {high_nibble_reg, digit[3:0]};
    assign sum_val    = running_sum_reg + byte_val;
    assign window_end = {1'b0, window_start_reg} + {1'b0, window_size_reg};
    assign in_window  = (record_address_reg >= {1'b0, window_start_reg})
                        && (record_address_reg < window_end);

    // ------------------------------------------------------------------
    // Parser step for one accepted transaction
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next          = phase_reg;
        high_nibble_next    = high_nibble_reg;
        second_digit_next   = second_digit_reg;
        bytes_left_next     = bytes_left_reg;
        record_address_next = record_address_reg;
        running_sum_next    = running_sum_reg;
        finished_next       = finished_reg;

        emit              = 1'b0;
        result_kind_next  = RESULT_FINISH;
        write_offset_next = 16'd0;
        write_data_next   = 8'd0;
        status_next       = STATUS_OK;

        if (kind == KIND_END)
        begin
            // Report the end unless loading already finished, then re-arm.
            if (!finished_reg)
            begin
                emit = 1'b1;
                status_next = (phase_reg == PH_COLON || phase_reg == PH_SKIP)
                              ? STATUS_OK : STATUS_PARSE;
            end
            phase_next          = PH_COLON;
            high_nibble_next    = 4'd0;
            second_digit_next   = 1'b0;
            bytes_left_next     = 8'd0;
            record_address_next = 17'd0;
            running_sum_next    = 8'd0;
            finished_next       = 1'b0;
        end
        else if (!finished_reg)
        begin
            case (phase_reg)
                PH_COLON:
                begin
                    if (character != CHAR_COLON)
                    begin
                        emit          = 1'b1;
                        status_next   = STATUS_PARSE;
                        finished_next = 1'b1;
                    end
                    else
                    begin
                        phase_next        = PH_COUNT;
                        second_digit_next = 1'b0;
                        running_sum_next  = 8'd0;
                    end
                end
                PH_SKIP:
                begin
                    if (character == CHAR_NEWLINE)
                        phase_next = PH_COLON;
                end
                default:
                begin
                    if (!digit[4])
                    begin
                        emit          = 1'b1;
                        status_next   = STATUS_PARSE;
                        finished_next = 1'b1;
                    end
                    else if (!second_digit_reg)
                    begin
                        high_nibble_next  = digit[3:0];
                        second_digit_next = 1'b1;
                    end
                    else
                    begin
                        second_digit_next = 1'b0;
                        running_sum_next  = sum_val;
                        case (phase_reg)
                            PH_COUNT:
                            begin
                                bytes_left_next = byte_val;
                                phase_next      = PH_ADDR_HI;
                            end
                            PH_ADDR_HI:
                            begin
                                record_address_next = {1'b0, byte_val, 8'd0};
                                phase_next          = PH_ADDR_LO;
                            end
                            PH_ADDR_LO:
                            begin
                                record_address_next = {record_address_reg[16:8], byte_val};
                                phase_next          = PH_TYPE;
                            end
                            PH_TYPE:
                            begin
                                if (byte_val == REC_DATA)
                                    phase_next = (bytes_left_reg != 8'd0) ? PH_DATA : PH_CHECK;
                                else
                                begin
                                    emit          = 1'b1;
                                    status_next   = (byte_val == REC_EOF)
                                                    ? STATUS_OK : STATUS_TYPE;
                                    finished_next = 1'b1;
                                end
                            end
                            PH_DATA:
                            begin
                                emit = 1'b1;
                                if (!in_window)
                                begin
                                    status_next   = STATUS_RANGE;
                                    finished_next = 1'b1;
                                end
                                else
                                begin
                                    // Write goes out before the checksum is seen.
                                    result_kind_next    = RESULT_WRITE;
                                    write_offset_next   = record_address_reg[15:0]
                                                          - window_start_reg;
                                    write_data_next     = byte_val;
                                    record_address_next = record_address_reg + 17'd1;
                                    bytes_left_next     = bytes_left_reg - 8'd1;
                                    if (bytes_left_reg == 8'd1)
                                        phase_next = PH_CHECK;
                                end
                            end
                            PH_CHECK:
                            begin
                                if (sum_val != 8'd0)
                                begin
                                    emit          = 1'b1;
                                    status_next   = STATUS_CHECKSUM;
                                    finished_next = 1'b1;
                                end
                                else
                                    phase_next = PH_SKIP;
                            end
                            default:
                            begin
                                emit          = 1'b1;
                                status_next   = STATUS_PARSE;
                                finished_next = 1'b1;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_start_reg <= 16'd0;
            window_size_reg  <= 16'd4096;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WINDOW_START: window_start_reg <= cfg_data;
                CFG_WINDOW_SIZE:  window_size_reg  <= cfg_data;
                default:          window_start_reg <= window_start_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Parser state registers: advance on every accepted transaction
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_COLON;
            high_nibble_reg    <= 4'd0;
            second_digit_reg   <= 1'b0;
            bytes_left_reg     <= 8'd0;
            record_address_reg <= 17'd0;
            running_sum_reg    <= 8'd0;
            finished_reg       <= 1'b0;
        end
        else if (char_accept)
        begin
            phase_reg          <= phase_next;
            high_nibble_reg    <= high_nibble_next;
            second_digit_reg   <= second_digit_next;
            bytes_left_reg     <= bytes_left_next;
            record_address_reg <= record_address_next;
            running_sum_reg    <= running_sum_next;
            finished_reg       <= finished_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register: load a new result, or drop the old one once taken
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (char_accept && emit)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (char_accept && emit)
        begin
            result_kind_reg  <= result_kind_next;
            write_offset_reg <= write_offset_next;
            write_data_reg   <= write_data_next;
            status_reg       <= status_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_kind  = result_kind_reg;
    assign write_offset = write_offset_reg;
    assign write_data   = write_data_reg;
    assign status       = status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `IHEX_ASSERT_SAME(a_stall_only_when_full, char_stall, result_valid_reg)
    `IHEX_ASSERT_SAME(a_data_phase_has_bytes, phase_reg == PH_DATA, bytes_left_reg != 8'd0)
    `IHEX_ASSERT_SAME(a_write_status_ok,
        result_valid_reg && result_kind_reg == RESULT_WRITE, status_reg == STATUS_OK)
    `IHEX_ASSERT_NEXT(a_end_rearms, char_accept && kind == KIND_END,
        phase_reg == PH_COLON && !finished_reg)

endmodule
